// ===== rtl/core/fud_pkg.sv =====
// Shared types, character codes and the hex-digit decode for the form pair decoder.
// No dependencies; used by every module in rtl/core.
package fud_pkg;

    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_EQUALS    = 8'h3D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] SEP_RESET    = 8'h26;

    localparam logic [1:0] ESC_NONE     = 2'd0;
    localparam logic [1:0] ESC_HIGH     = 2'd1;
    localparam logic [1:0] ESC_LOW      = 2'd2;

    localparam logic [0:0] REG_SEPARATOR = 1'b0;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       in_value;
        logic       pair_end;
        logic       value_present;
        logic       bad_request;
        logic       run_last;
    } t_result;

    // all results caused by one input byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_bundle;

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            res = {1'b1, c[3:0] + 4'd9};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/fud_front.sv =====
// Front end: takes body bytes, tracks escape/key-value/drop state, builds result bundles.
// Depends on fud_pkg.
module fud_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_in_byte,
    input  logic            i_body_end,
    input  logic [7:0]      i_separator,
    output logic            o_wr,
    output fud_pkg::t_bundle o_bundle
);
    import fud_pkg::*;

    logic [1:0] r_esc, n_esc;
    logic [3:0] r_nib, n_nib;
    logic       r_vm, n_vm;
    logic       r_drop, n_drop;

    t_result    emit_res;
    logic       emit;
    logic       bad;
    logic [4:0] hx;
    logic [7:0] dec;
    t_bundle    bnd;

    assign hx  = hex_digit(i_in_byte);
    assign dec = {r_nib, hx[3:0]};

    always_comb begin
        n_esc    = r_esc;
        n_nib    = r_nib;
        n_vm     = r_vm;
        n_drop   = r_drop;
        emit     = 1'b0;
        bad      = 1'b0;
        emit_res = '0;
        bnd      = '0;
        if (r_drop) begin
            if (i_body_end) begin
                n_drop = 1'b0;
                n_esc  = ESC_NONE;
                n_nib  = 4'd0;
                n_vm   = 1'b0;
            end
        end else begin
            if (r_esc != ESC_NONE) begin
                if (i_in_byte == i_separator || i_in_byte == CH_EQUALS || !hx[4]) begin
                    bad = 1'b1;
                end else if (r_esc == ESC_HIGH) begin
                    n_nib = hx[3:0];
                    n_esc = ESC_LOW;
                    bad   = i_body_end;
                end else begin
                    n_esc = ESC_NONE;
                    n_nib = 4'd0;
                    if (dec == 8'd0) begin
                        bad = 1'b1;
                    end else begin
                        emit                = 1'b1;
                        emit_res.out_byte   = dec;
                        emit_res.byte_valid = 1'b1;
                        emit_res.in_value   = r_vm;
                    end
                end
            end else if (i_in_byte == i_separator) begin
                emit                   = 1'b1;
                emit_res.pair_end      = 1'b1;
                emit_res.value_present = r_vm;
                n_vm                   = 1'b0;
            end else if (i_in_byte == CH_EQUALS && !r_vm) begin
                n_vm = 1'b1;
            end else if (i_in_byte == CH_PLUS) begin
                emit                = 1'b1;
                emit_res.out_byte   = CH_SPACE;
                emit_res.byte_valid = 1'b1;
                emit_res.in_value   = r_vm;
            end else if (i_in_byte == CH_PERCENT) begin
                n_esc = ESC_HIGH;
                bad   = i_body_end;
            end else begin
                emit                = 1'b1;
                emit_res.out_byte   = i_in_byte;
                emit_res.byte_valid = 1'b1;
                emit_res.in_value   = r_vm;
            end

            if (bad) begin
                bnd.cnt            = 2'd1;
                bnd.r0.bad_request = 1'b1;
                bnd.r0.run_last    = 1'b1;
                n_drop             = !i_body_end;
            end else if (i_body_end) begin
                if (emit) begin
                    bnd.cnt = 2'd2;
                    bnd.r0  = emit_res;
                    bnd.r1.pair_end      = 1'b1;
                    bnd.r1.value_present = n_vm;
                    bnd.r1.run_last      = 1'b1;
                end else begin
                    bnd.cnt = 2'd1;
                    bnd.r0.pair_end      = 1'b1;
                    bnd.r0.value_present = n_vm;
                    bnd.r0.run_last      = 1'b1;
                end
            end else if (emit) begin
                bnd.cnt         = 2'd1;
                bnd.r0          = emit_res;
                bnd.r0.run_last = 1'b1;
            end

            if (i_body_end) begin
                n_esc = ESC_NONE;
                n_nib = 4'd0;
                n_vm  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= ESC_NONE;
            r_nib  <= 4'd0;
            r_vm   <= 1'b0;
            r_drop <= 1'b0;
        end else if (i_accept) begin
            r_esc  <= n_esc;
            r_nib  <= n_nib;
            r_vm   <= n_vm;
            r_drop <= n_drop;
        end
    end

    assign o_wr     = i_accept && (bnd.cnt != 2'd0);
    assign o_bundle = bnd;

endmodule

// ===== rtl/core/fud_fifo.sv =====
// Short bundle queue between front and back ends.
// Depends on fud_pkg.
module fud_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  fud_pkg::t_bundle i_wdata,
    input  logic             i_rd,
    output fud_pkg::t_bundle o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    import fud_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_en, rd_en;

    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT) else $error("queue count overflow");

    a_bundle_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (i_wdata.cnt == 2'd1 || i_wdata.cnt == 2'd2))
        else $error("empty bundle queued");

endmodule

// ===== rtl/core/fud_back.sv =====
// Back end: output register that hands out the results of each bundle one per pop.
// Depends on fud_pkg.
module fud_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  fud_pkg::t_bundle i_q_data,
    output logic             o_q_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output fud_pkg::t_result o_res
);
    import fud_pkg::*;

    logic    r_valid;
    logic    r_sel;
    t_bundle r_bnd;
    logic    pop_en;
    logic    done;

    assign pop_en  = i_pop && r_valid;
    assign done    = pop_en && (r_sel || r_bnd.cnt != 2'd2);
    assign o_q_rd  = !i_q_empty && (!r_valid || done);
    assign o_empty = !r_valid;
    assign o_res   = r_sel ? r_bnd.r1 : r_bnd.r0;

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_bnd <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
            r_sel   <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (pop_en) begin
            r_sel   <= 1'b1;
        end
    end

    a_sel_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sel) |-> (r_bnd.cnt == 2'd2)) else $error("second slot without result");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_sel || r_bnd.cnt == 2'd1)) |-> o_res.run_last)
        else $error("final result of a bundle lacks run_last");

endmodule

// ===== rtl/core/form_urlencoded_pair_decoder.sv =====
// Form body (x-www-form-urlencoded) pair decoder, top level.
// Depends on fud_pkg, fud_front, fud_fifo, fud_back.
// Takes one body byte per cycle (push/full) and returns decoded key and value bytes,
// pair ends and bad-escape reports (empty/pop), one result per cycle. A byte causes
// zero, one or two results; the front end decodes each byte in the cycle it is
// accepted, so input throughput is one byte per cycle as long as the DEPTH-entry queue
// in front of the output register has room. A result passes the queue and the output
// register before it reaches the ports. The separator byte (reset '&') is set through
// APB address 0; users must set it only while the block is idle (the block never checks).
module form_urlencoded_pair_decoder #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_body_end,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_in_value,
    output logic        o_pair_end,
    output logic        o_value_present,
    output logic        o_bad_request,
    output logic        o_run_last
);
    import fud_pkg::*;

    logic [7:0] r_sep;
    logic       in_acc;
    logic       q_wr, q_rd, q_full, q_empty;
    t_bundle    q_wdata, q_rdata;
    t_result    res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEPARATOR) ? {24'd0, r_sep} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_SEPARATOR) begin
            r_sep <= pwdata[7:0];
        end
    end

    assign full   = q_full;
    assign in_acc = push && !q_full;

    fud_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_acc),
        .i_in_byte   (i_in_byte),
        .i_body_end  (i_body_end),
        .i_separator (r_sep),
        .o_wr        (q_wr),
        .o_bundle    (q_wdata)
    );

    fud_fifo #(.DEPTH(DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fud_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_out_byte      = res.out_byte;
    assign o_byte_valid    = res.byte_valid;
    assign o_in_value      = res.in_value;
    assign o_pair_end      = res.pair_end;
    assign o_value_present = res.value_present;
    assign o_bad_request   = res.bad_request;
    assign o_run_last      = res.run_last;

endmodule

// ===== dv/form_urlencoded_pair_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for form_urlencoded_pair_decoder: directed and random form bodies
// under several separator settings, with a scoreboard class that predicts every result.
// Depends on fud_pkg and the form_urlencoded_pair_decoder RTL.
module form_urlencoded_pair_decoder_test;
    import fud_pkg::*;

    class pair_scoreboard;
        logic [7:0] separator;
        logic [1:0] esc_phase;
        logic [3:0] high_nib;
        logic       value_mode;
        logic       dropping;
        t_result    pending_results[$];
        int         errors;
        int         n_results;
        int         n_pairs;
        int         n_bad;

        function new();
            separator = SEP_RESET;
            clear_body();
        endfunction

        function void clear_body();
            esc_phase = ESC_NONE;
            high_nib = 4'd0;
            value_mode = 1'b0;
            dropping = 1'b0;
        endfunction

        function t_result mk(logic [7:0] ob, logic bv, logic iv, logic pe, logic vp,
                             logic br);
            t_result r;
            r.out_byte = ob;
            r.byte_valid = bv;
            r.in_value = iv;
            r.pair_end = pe;
            r.value_present = vp;
            r.bad_request = br;
            r.run_last = 1'b0;
            return r;
        endfunction

        // predict the results caused by one accepted body byte
        function void decode_byte(logic [7:0] b, logic last);
            t_result res[$];
            logic    bad;
            logic    is_hex;
            logic [3:0] nib;
            logic [7:0] v;
            bad = 1'b0;
            if (dropping) begin
                if (last) clear_body();
                return;
            end
            is_hex = 1'b1;
            nib = 4'd0;
            if (b >= 8'h30 && b <= 8'h39) nib = 4'(b - 8'h30);
            else if (b >= 8'h61 && b <= 8'h66) nib = 4'(b - 8'h61 + 8'd10);
            else if (b >= 8'h41 && b <= 8'h46) nib = 4'(b - 8'h41 + 8'd10);
            else is_hex = 1'b0;

            if (esc_phase != ESC_NONE) begin
                if (b == separator || b == CH_EQUALS || !is_hex) begin
                    bad = 1'b1;
                end else if (esc_phase == ESC_HIGH) begin
                    high_nib = nib;
                    esc_phase = ESC_LOW;
                    if (last) bad = 1'b1;
                end else begin
                    v = {high_nib, nib};
                    esc_phase = ESC_NONE;
                    high_nib = 4'd0;
                    if (v == 8'd0) bad = 1'b1;
                    else res.push_back(mk(v, 1'b1, value_mode, 1'b0, 1'b0, 1'b0));
                end
            end else if (b == separator) begin
                res.push_back(mk(8'd0, 1'b0, 1'b0, 1'b1, value_mode, 1'b0));
                value_mode = 1'b0;
            end else if (b == CH_EQUALS && !value_mode) begin
                value_mode = 1'b1;
            end else if (b == CH_PLUS) begin
                res.push_back(mk(CH_SPACE, 1'b1, value_mode, 1'b0, 1'b0, 1'b0));
            end else if (b == CH_PERCENT) begin
                esc_phase = ESC_HIGH;
                if (last) bad = 1'b1;
            end else begin
                res.push_back(mk(b, 1'b1, value_mode, 1'b0, 1'b0, 1'b0));
            end

            if (bad) begin
                res.delete();
                res.push_back(mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
                if (last) clear_body();
                else dropping = 1'b1;
            end else if (last) begin
                res.push_back(mk(8'd0, 1'b0, 1'b0, 1'b1, value_mode, 1'b0));
                clear_body();
            end
            if (res.size() > 0) res[res.size() - 1].run_last = 1'b1;
            foreach (res[i]) pending_results.push_back(res[i]);
        endfunction

        function void cmp(string f, logic [7:0] e, logic [7:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, f, e, a);
            end
        endfunction

        function void check_result(t_result got);
            t_result e;
            n_results++;
            if (got.pair_end) n_pairs++;
            if (got.bad_request) n_bad++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing actual %h",
                         $time, got);
                return;
            end
            e = pending_results.pop_front();
            cmp("out_byte", e.out_byte, got.out_byte);
            cmp("byte_valid", 8'(e.byte_valid), 8'(got.byte_valid));
            cmp("in_value", 8'(e.in_value), 8'(got.in_value));
            cmp("pair_end", 8'(e.pair_end), 8'(got.pair_end));
            cmp("value_present", 8'(e.value_present), 8'(got.value_present));
            cmp("bad_request", 8'(e.bad_request), 8'(got.bad_request));
            cmp("run_last", 8'(e.run_last), 8'(got.run_last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic [7:0]  i_in_byte;
    logic        i_body_end;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_in_value;
    logic        o_pair_end;
    logic        o_value_present;
    logic        o_bad_request;
    logic        o_run_last;

    pair_scoreboard sb = new();
    int send_idle;
    int recv_idle;
    int n_sent;
    int n_accepted;
    bit hold_req;

    form_urlencoded_pair_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_body_end      (i_body_end),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_in_value      (o_in_value),
        .o_pair_end      (o_pair_end),
        .o_value_present (o_value_present),
        .o_bad_request   (o_bad_request),
        .o_run_last      (o_run_last)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // transaction monitor: both sides sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            sb.decode_byte(i_in_byte, i_body_end);
            n_accepted++;
        end
        if (i_rst_n && pop && !empty) begin
            sb.check_result({o_out_byte, o_byte_valid, o_in_value, o_pair_end,
                             o_value_present, o_bad_request, o_run_last});
        end
    end

    // result side: random stalls, long hold-off on request
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (80) @(posedge i_clk);
            end else begin
                pop <= i_rst_n && ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_byte <= b;
        i_body_end <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_separator(logic [7:0] sep);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_SEPARATOR, 2'b00};
        pwdata <= {24'd0, sep};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.separator = sep;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    // mostly well-formed pairs with random content, some noise and broken escapes
    task automatic send_random_body();
        logic [7:0] q[$];
        int ntok;
        int r;
        ntok = $urandom_range(1, 10);
        repeat (ntok) begin
            r = $urandom_range(99);
            if (r < 35) q.push_back(8'($urandom_range(255)));
            else if (r < 50) q.push_back(CH_PLUS);
            else if (r < 60) q.push_back(CH_EQUALS);
            else if (r < 70) q.push_back(sb.separator);
            else if (r < 88) begin
                q.push_back(CH_PERCENT);
                q.push_back(hex_char(4'($urandom_range(15))));
                q.push_back(hex_char(4'($urandom_range(15))));
            end else if (r < 94) begin
                q.push_back(CH_PERCENT);
                q.push_back(8'($urandom_range(255)));
            end else begin
                q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            end
        end
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic run_phase(logic [7:0] sep, int s_idle, int r_idle, int n, bit hold);
        int start;
        bit held;
        drain();
        set_separator(sep);
        send_idle = s_idle;
        recv_idle = r_idle;
        start = n_sent;
        held = 1'b0;
        while (n_sent - start < n) begin
            if (hold && !held && n_sent - start >= n / 2) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            send_random_body();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        push <= 1'b0;
        i_in_byte <= 8'd0;
        i_body_end <= 1'b0;
        send_idle = 31;
        recv_idle = 46;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed bodies at the reset separator
        send_text("a=%4A+%7e=&");
        send_text("%0g");
        send_text("%00x");
        send_text("%");
        send_text("%4");
        send_text("%&z");
        send_text("%=");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        run_phase(SEP_RESET, 31, 46, 200, 1'b1);
        run_phase(8'h00, 31, 46, 200, 1'b0);
        run_phase(8'hFF, 46, 31, 200, 1'b0);
        run_phase(CH_EQUALS, 46, 31, 200, 1'b1);
        run_phase(CH_PERCENT, 0, 0, 200, 1'b0);
        run_phase(8'h3B, 0, 0, 200, 1'b0);
        drain();

        $display("Run covered %0d body bytes and %0d results (%0d pair ends, %0d bad escapes)",
                 n_accepted, sb.n_results, sb.n_pairs, sb.n_bad);
        $display("over six separator settings including 0x00, 0xFF, '=' and '%%'.");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding", sb.pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/fud_pkg.sv
rtl/core/fud_front.sv
rtl/core/fud_fifo.sv
rtl/core/fud_back.sv
rtl/core/form_urlencoded_pair_decoder.sv
dv/form_urlencoded_pair_decoder_test.sv
